// ===== design/voxel_ray_traversal_clipped_assert.svh =====
// ----------------------------------------------------------------------------
// Voxel ray walker assertion macros
// Concurrent checks that go away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef VOXEL_RAY_TRAVERSAL_CLIPPED_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_CLIPPED_ASSERT_SVH
`ifndef SYNTHESIS
`define VRT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("voxel ray walker check failed");
`define VRT_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("voxel ray walker check failed");
`else
`define VRT_ASSERT(lbl, clk, rstn, prop)
`define VRT_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== design/vrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel ray walker package
// Sequencer states, result status codes and register indexes.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int OUT_W     = 12;
  localparam int BOX_W     = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;

  localparam logic signed [BOX_W-1:0] BOX_MIN_RST = -13'sd2048;
  localparam logic signed [BOX_W-1:0] BOX_MAX_RST = 13'sd2048;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_CHECK,
    ST_DECIDE,
    ST_EMIT,
    ST_STEP
  } state_e;

  typedef enum logic [2:0] {
    STAT_CONT   = 3'd0,
    STAT_END    = 3'd1,
    STAT_DIST   = 3'd2,
    STAT_OVF    = 3'd3,
    STAT_NOMORE = 3'd4,
    STAT_DEGEN  = 3'd5
  } status_e;

endpackage

// ===== design/voxel_ray_traversal_clipped.sv =====
// Setup: squaring for the ray length, then two divisions per moving axis (first crossing
// and increment), then the voxel walk; each voxel inside the box also gets a distance check.
// Throughput: one ray at a time; a new ray stalls until the last result is loaded for output.
// The one restoring divider (one quotient bit a cycle) and the single squarer serve all axes.
// Reset: asynchronous, active low; sequencer idles, output empty, box back to full range.
`include "voxel_ray_traversal_clipped_assert.svh"
// ----------------------------------------------------------------------------
// Clipped 3D voxel ray walker
// Floors both ray endpoints to voxels, derives per-axis crossing times with a
// shared serial divider, then steps voxel by voxel and sends out the voxels
// that fall inside the configured half-open box.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_clipped import vrt_pkg::*; #(
  parameter int COORD_INT_BITS  = 12,
  parameter int COORD_FRAC_BITS = 8,
  parameter int T_FRAC_BITS     = 24,
  parameter int MAX_VOXELS      = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // ray request channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_x_i,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_y_i,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_z_i,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_x_i,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_y_i,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_z_i,
  // result channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [OUT_W-1:0]                 voxel_x_o,
  output logic signed [OUT_W-1:0]                 voxel_y_o,
  output logic signed [OUT_W-1:0]                 voxel_z_o,
  output logic                                    voxel_valid_o,
  output logic [2:0]                              status_o,
  output logic                                    last_o,
  // box configuration channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                    cfg_index_i,
  input  logic [BOX_W-1:0]                        cfg_data_i
);

  localparam int CI   = COORD_INT_BITS;
  localparam int F    = COORD_FRAC_BITS;
  localparam int T    = T_FRAC_BITS;
  localparam int CW   = CI + F;           // coordinate width
  localparam int DW   = CW + 1;           // coordinate difference width
  localparam int SQW  = 2 * DW;           // one square
  localparam int ACCW = SQW + 2;          // sum of three squares
  localparam int TW   = T + 2;            // t value, unsigned Q2.T
  localparam int NUMW = F + 1 + T;        // dividend width
  localparam int QW   = (NUMW > TW) ? NUMW : TW;
  localparam int DVW  = CI + F;           // divisor |d| << F
  localparam int RW   = DVW + 1;
  localparam int CNTW = $clog2(QW + 1);
  localparam int WLW  = CI + 2;
  localparam int NW   = $clog2(MAX_VOXELS + 1);
  localparam int RFW  = (F > 0) ? F : 1;
  localparam int BCW  = ((CI > BOX_W) ? CI : BOX_W) + 1;
  localparam int VXW  = (CI > OUT_W) ? CI : OUT_W;

  localparam logic [TW-1:0]   T_ALL     = {TW{1'b1}};
  localparam logic [WLW-1:0]  WALK_LIM  = WLW'(3) << CI;
  localparam logic [F:0]      ONE       = (F + 1)'(1) << F;
  localparam logic [CW-1:0]   FMASK     = CW'((64'd1 << F) - 64'd1);
  localparam logic [CNTW-1:0] DIV_LAST  = CNTW'(QW - 1);
  localparam logic [NW:0]     MAX_N     = (NW + 1)'(MAX_VOXELS);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic signed [BOX_W-1:0] box_min_q [3];
  logic signed [BOX_W-1:0] box_max_q [3];

  logic signed [CW-1:0] s_q  [3];
  logic signed [CW-1:0] e_q  [3];
  logic signed [CI-1:0] v_q  [3];
  logic signed [CI-1:0] ev_q [3];
  logic [RFW-1:0]       r_q  [3];
  logic [2:0]           dpos_q, dneg_q;
  logic [TW-1:0]        t_q  [3];
  logic [TW-1:0]        dt_q [3];

  logic [SQW-1:0]  prod_q;
  logic [ACCW-1:0] acc_q, len_q;
  logic            mode_len_q;   // squarer sums the ray length, else a voxel distance

  logic [QW-1:0]   dd_q;         // dividend in, quotient out
  logic [DVW-1:0]  rem_q, dvs_q;
  logic [CNTW-1:0] cnt_q;
  logic            phase_q;      // 0: first crossing, 1: increment
  logic [1:0]      k_q;          // axis under work

  logic [WLW-1:0]  walk_q;
  logic [NW-1:0]   n_q;          // voxels sent for this ray

  // pending result, then the output register
  logic signed [CI-1:0] res_x_q, res_y_q, res_z_q;
  logic                 res_valid_q, res_last_q;
  status_e              res_status_q;

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_x_q, out_y_q, out_z_q;
  logic                    out_vv_q, out_last_q;
  status_e                 out_status_q;

  // --------------------------------------------------------------------------
  // Request decode: floor endpoints and spot a degenerate ray
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] in_s [3];
  logic signed [CW-1:0] in_e [3];
  logic signed [CI-1:0] in_v [3];
  logic signed [CI-1:0] in_ev [3];
  logic                 in_acc, in_degen;

  assign in_s[0] = start_x_i;
  assign in_s[1] = start_y_i;
  assign in_s[2] = start_z_i;
  assign in_e[0] = end_x_i;
  assign in_e[1] = end_y_i;
  assign in_e[2] = end_z_i;

  always_comb begin
    in_degen = 1'b1;
    for (int i = 0; i < 3; i++) begin
      in_v[i]  = CI'(in_s[i] >>> F);
      in_ev[i] = CI'(in_e[i] >>> F);
      if (in_v[i] != in_ev[i]) in_degen = 1'b0;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Shared squarer: |op|^2 for the ray length or a corner distance
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] sq_op;
  logic [DW-1:0]        sq_abs;
  logic [SQW-1:0]       sq_prod;

  always_comb begin
    if (mode_len_q) begin
      sq_op = DW'(e_q[k_q]) - DW'(s_q[k_q]);
    end else begin
      sq_op = (DW'(v_q[k_q]) <<< F) - DW'(s_q[k_q]);
    end
    sq_abs  = sq_op[DW-1] ? DW'(-sq_op) : DW'(sq_op);
    sq_prod = SQW'(sq_abs) * SQW'(sq_abs);
  end

  // --------------------------------------------------------------------------
  // Divider setup and one restoring step
  // --------------------------------------------------------------------------
  logic signed [CI:0] div_d;
  logic [CI-1:0]      div_ad;
  logic [F:0]         div_num;
  logic               axis_still;
  logic [RW-1:0]      rem_sh;
  logic               rem_ge;
  logic [QW-1:0]      quot;

  always_comb begin
    div_d      = (CI + 1)'(ev_q[k_q]) - (CI + 1)'(v_q[k_q]);
    div_ad     = div_d[CI] ? CI'(-div_d) : CI'(div_d);
    axis_still = !dpos_q[k_q] && !dneg_q[k_q];
    if (phase_q) begin
      div_num = ONE;
    end else if (dpos_q[k_q]) begin
      div_num = ONE - (F + 1)'(r_q[k_q]);
    end else if (r_q[k_q] == '0) begin
      div_num = ONE;
    end else begin
      div_num = (F + 1)'(r_q[k_q]);
    end
    rem_sh = {rem_q, dd_q[QW-1]};
    rem_ge = (rem_sh >= RW'(dvs_q));
    quot   = dd_q;
  end

  // --------------------------------------------------------------------------
  // Walk: box test, end test, axis choice, saturated t update
  // --------------------------------------------------------------------------
  logic          inbox, atend;
  logic [1:0]    ax;
  logic [TW:0]   t_sum;
  logic [TW-1:0] t_new;
  logic          dist_over;
  logic          n_full;

  always_comb begin
    inbox = 1'b1;
    atend = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (BCW'(v_q[i]) < BCW'(box_min_q[i]) || BCW'(v_q[i]) >= BCW'(box_max_q[i])) begin
        inbox = 1'b0;
      end
      if (v_q[i] != ev_q[i]) atend = 1'b0;
    end
    // ties go to z, then y
    if (t_q[0] < t_q[1]) begin
      ax = (t_q[0] < t_q[2]) ? 2'd0 : 2'd2;
    end else begin
      ax = (t_q[1] < t_q[2]) ? 2'd1 : 2'd2;
    end
    t_sum     = {1'b0, t_q[ax]} + {1'b0, dt_q[ax]};
    t_new     = t_sum[TW] ? T_ALL : t_sum[TW-1:0];
    dist_over = (acc_q > len_q);
    n_full    = ((NW + 1)'(n_q) + (NW + 1)'(1) >= MAX_N);
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state and output register control
  // --------------------------------------------------------------------------
  logic out_free, out_load;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = in_degen ? ST_EMIT : ST_SQ;
      end
      ST_SQ: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (k_q == 2'd2) state_d = mode_len_q ? ST_DIV_INIT : ST_DECIDE;
        else state_d = ST_SQ;
      end
      ST_DIV_INIT: begin
        if (!axis_still) state_d = ST_DIV_RUN;
        else if (k_q == 2'd2) state_d = ST_CHECK;
      end
      ST_DIV_RUN: begin
        if (cnt_q == DIV_LAST) state_d = ST_DIV_DONE;
      end
      ST_DIV_DONE: begin
        state_d = (phase_q && k_q == 2'd2) ? ST_CHECK : ST_DIV_INIT;
      end
      ST_CHECK: begin
        if (inbox) state_d = ST_SQ;
        else if (atend) state_d = ST_EMIT;
        else state_d = ST_STEP;
      end
      ST_DECIDE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = res_last_q ? ST_IDLE : ST_STEP;
        end
      end
      ST_STEP: begin
        state_d = (walk_q >= WALK_LIM) ? ST_EMIT : ST_CHECK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      mode_len_q  <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        box_min_q[i] <= BOX_MIN_RST;
        box_max_q[i] <= BOX_MAX_RST;
      end
    end else begin
      state_q <= state_d;

      // hold the result while stalled, drop it once taken
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_BOX_MIN_X: box_min_q[0] <= cfg_data_i;
          CFG_BOX_MIN_Y: box_min_q[1] <= cfg_data_i;
          CFG_BOX_MIN_Z: box_min_q[2] <= cfg_data_i;
          CFG_BOX_MAX_X: box_max_q[0] <= cfg_data_i;
          CFG_BOX_MAX_Y: box_max_q[1] <= cfg_data_i;
          CFG_BOX_MAX_Z: box_max_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            n_q        <= '0;
            k_q        <= '0;
            phase_q    <= 1'b0;
            mode_len_q <= 1'b1;
          end
        end
        ST_ACC: begin
          k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        end
        ST_DIV_INIT: begin
          cnt_q <= '0;
          if (axis_still) begin
            phase_q <= 1'b0;
            k_q     <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
          end
        end
        ST_DIV_RUN: begin
          cnt_q <= cnt_q + CNTW'(1);
        end
        ST_DIV_DONE: begin
          phase_q <= !phase_q;
          if (phase_q) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        end
        ST_CHECK: begin
          if (inbox) begin
            k_q        <= '0;
            mode_len_q <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (out_load && res_valid_q) n_q <= n_q + NW'(1);
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < 3; i++) begin
            s_q[i]    <= in_s[i];
            e_q[i]    <= in_e[i];
            v_q[i]    <= in_v[i];
            ev_q[i]   <= in_ev[i];
            r_q[i]    <= RFW'(in_s[i] & FMASK);
            dpos_q[i] <= (in_ev[i] > in_v[i]);
            dneg_q[i] <= (in_ev[i] < in_v[i]);
          end
          acc_q        <= '0;
          walk_q       <= '0;
          res_x_q      <= '0;
          res_y_q      <= '0;
          res_z_q      <= '0;
          res_valid_q  <= 1'b0;
          res_status_q <= STAT_DEGEN;
          res_last_q   <= 1'b1;
        end
      end
      ST_SQ: begin
        prod_q <= sq_prod;
      end
      ST_ACC: begin
        acc_q <= acc_q + ACCW'(prod_q);
        if (k_q == 2'd2 && mode_len_q) len_q <= acc_q + ACCW'(prod_q);
      end
      ST_DIV_INIT: begin
        if (axis_still) begin
          t_q[k_q]  <= T_ALL;
          dt_q[k_q] <= T_ALL;
        end else begin
          dd_q  <= QW'(div_num) << T;
          rem_q <= '0;
          dvs_q <= DVW'(div_ad) << F;
        end
      end
      ST_DIV_RUN: begin
        rem_q <= rem_ge ? DVW'(rem_sh - RW'(dvs_q)) : DVW'(rem_sh);
        dd_q  <= {dd_q[QW-2:0], rem_ge};
      end
      ST_DIV_DONE: begin
        if (phase_q) dt_q[k_q] <= (quot > QW'(T_ALL)) ? T_ALL : TW'(quot);
        else t_q[k_q] <= (quot > QW'(T_ALL)) ? T_ALL : TW'(quot);
      end
      ST_CHECK: begin
        if (inbox) begin
          acc_q <= '0;
        end else if (atend) begin
          res_x_q      <= '0;
          res_y_q      <= '0;
          res_z_q      <= '0;
          res_valid_q  <= 1'b0;
          res_status_q <= STAT_NOMORE;
          res_last_q   <= 1'b1;
        end
      end
      ST_DECIDE: begin
        res_x_q     <= v_q[0];
        res_y_q     <= v_q[1];
        res_z_q     <= v_q[2];
        res_valid_q <= 1'b1;
        if (dist_over) begin
          res_status_q <= STAT_DIST;
          res_last_q   <= 1'b1;
        end else if (atend) begin
          res_status_q <= STAT_END;
          res_last_q   <= 1'b1;
        end else if (n_full) begin
          res_status_q <= STAT_OVF;
          res_last_q   <= 1'b1;
        end else begin
          res_status_q <= STAT_CONT;
          res_last_q   <= 1'b0;
        end
      end
      ST_STEP: begin
        if (walk_q >= WALK_LIM) begin
          // runaway walk: give up with a terminator
          res_x_q      <= '0;
          res_y_q      <= '0;
          res_z_q      <= '0;
          res_valid_q  <= 1'b0;
          res_status_q <= STAT_OVF;
          res_last_q   <= 1'b1;
        end else begin
          if (dpos_q[ax]) v_q[ax] <= v_q[ax] + CI'(1);
          else if (dneg_q[ax]) v_q[ax] <= v_q[ax] - CI'(1);
          t_q[ax] <= t_new;
          walk_q  <= walk_q + WLW'(1);
        end
      end
      default: ;
    endcase
  end

  // output register payload
  logic signed [VXW-1:0] ox, oy, oz;

  assign ox = VXW'(res_x_q);
  assign oy = VXW'(res_y_q);
  assign oz = VXW'(res_z_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q      <= ox[OUT_W-1:0];
      out_y_q      <= oy[OUT_W-1:0];
      out_z_q      <= oz[OUT_W-1:0];
      out_vv_q     <= res_valid_q;
      out_status_q <= res_status_q;
      out_last_q   <= res_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign voxel_x_o     = out_x_q;
  assign voxel_y_o     = out_y_q;
  assign voxel_z_o     = out_z_q;
  assign voxel_valid_o = out_vv_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;
  assign cfg_ready_o   = 1'b1;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `VRT_ASSERT(a_term_zero, clk_i, rst_ni, (out_valid_o && !voxel_valid_o) |-> (voxel_x_o == '0 && voxel_y_o == '0 && voxel_z_o == '0 && last_o))
  `VRT_ASSERT(a_cont_not_last, clk_i, rst_ni, (out_valid_o && status_o == STAT_CONT) |-> (!last_o && voxel_valid_o))
  `VRT_ASSERT(a_count_bound, clk_i, rst_ni, (NW + 1)'(n_q) <= MAX_N)
  `VRT_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_acc, in_stall_o)

endmodule
